// ----- rtl/dspf_pkg.sv -----
package dspf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 12;
    localparam int FILL_W   = 10;

    localparam logic [CODE_W-1:0] CODE_OFFSET = 12'h800;

    // Item kinds on the input channel.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Status of one item, carried from the pointer stage to the output stage.
    typedef struct packed {
        logic              accepted;
        logic              code_valid;
        logic              underrun;
        logic [FILL_W-1:0] fill_level;
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [CODE_W-1:0] dac_code;
    } t_result;

    // Restores byte order, keeps the top 12 bits and moves to offset binary.
    // The 12-bit add wraps, which is the same as masking to 12 bits.
    function automatic logic [CODE_W-1:0] sample_to_code(input logic [SAMPLE_W-1:0] w);
        logic [SAMPLE_W-1:0] swapped;
        swapped = {w[7:0], w[15:8]};
        return swapped[SAMPLE_W-1:SAMPLE_W-CODE_W] + CODE_OFFSET;
    endfunction

endpackage

// ----- rtl/dspf_if.sv -----
interface dspf_in_if import dspf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [SAMPLE_W-1:0] sample_word;

    modport source (output valid, output kind, output sample_word, input ready);
    modport sink   (input valid, input kind, input sample_word, output ready);
endinterface

interface dspf_out_if import dspf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              code_valid;
    logic [CODE_W-1:0] dac_code;
    logic              underrun;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, output accepted, output code_valid, output dac_code,
                    output underrun, output fill_level, input ready);
    modport sink   (input valid, input accepted, input code_valid, input dac_code,
                    input underrun, input fill_level, output ready);
endinterface

// ----- rtl/dac_sample_playout_fifo.sv -----
// Channel   Direction  Word
// i_in      in         kind (push or tick), sample_word (byte-swapped signed sample)
// o_out     out        accepted, code_valid, dac_code, underrun, fill_level
//
// One word is taken per cycle unless stalled; its result passes r_s1, then r_out.
// Pointers and the entry count update in the cycle a word is taken, and the code
// memory is written (push) or read (tick) at that same edge, so the single-port
// access per word sets the rate. A pop always reads an entry written in an earlier
// cycle, so no forwarding is needed. Reset clears pointers and count; the memory
// is not cleared. A stalled output holds its word and backs up into i_in.ready.
module dac_sample_playout_fifo
    import dspf_pkg::*;
#(
    parameter int DEPTH = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dspf_in_if.sink      i_in,
    dspf_out_if.source   o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CODE_W-1:0] r_mem [DEPTH];
    logic [CODE_W-1:0] r_rd_data;

    logic [AW-1:0] r_wr_pos, n_wr_pos;
    logic [AW-1:0] r_rd_pos, n_rd_pos;
    logic [CW-1:0] r_count, n_count;

    t_status r_s1, n_s1;
    logic    r_s1_valid;
    t_result r_out;
    logic    r_out_valid;

    logic          take;
    logic          s1_move;
    logic          do_push;
    logic          do_pop;
    logic [FILL_W-1:0] fill_next;

    assign s1_move     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_move;
    assign take        = i_in.valid && i_in.ready;
    assign do_push     = take && (i_in.kind == KIND_PUSH) && (r_count != FULL_CNT);
    assign do_pop      = take && (i_in.kind == KIND_TICK) && (r_count != '0);

    generate
        if (CW >= FILL_W) begin : g_fill_trunc
            assign fill_next = n_count[FILL_W-1:0];
        end else begin : g_fill_ext
            assign fill_next = {{(FILL_W-CW){1'b0}}, n_count};
        end
    endgenerate

    always_comb begin
        n_wr_pos = r_wr_pos;
        n_rd_pos = r_rd_pos;
        n_count  = r_count;
        if (do_push) begin
            n_wr_pos = (r_wr_pos == LAST_POS) ? '0 : r_wr_pos + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (do_pop) begin
            n_rd_pos = (r_rd_pos == LAST_POS) ? '0 : r_rd_pos + 1'b1;
            n_count  = r_count - 1'b1;
        end
        n_s1.accepted   = do_push;
        n_s1.code_valid = do_pop;
        n_s1.underrun   = take && (i_in.kind == KIND_TICK) && (r_count == '0);
        n_s1.fill_level = fill_next;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_pos] <= sample_to_code(i_in.sample_word);
        end
        if (do_pop) begin
            r_rd_data <= r_mem[r_rd_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pos <= n_wr_pos;
            r_rd_pos <= n_rd_pos;
            r_count  <= n_count;
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out.status   <= r_s1;
            r_out.dac_code <= r_s1.code_valid ? r_rd_data : '0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.accepted   = r_out.status.accepted;
    assign o_out.code_valid = r_out.status.code_valid;
    assign o_out.dac_code   = r_out.dac_code;
    assign o_out.underrun   = r_out.status.underrun;
    assign o_out.fill_level = r_out.status.fill_level;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_full_refuses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (i_in.kind == KIND_PUSH) && (r_count == FULL_CNT)
        |=> r_s1_valid && !r_s1.accepted && (r_count == FULL_CNT))
        else $error("push stored on a full ring");

    a_empty_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (i_in.kind == KIND_TICK) && (r_count == '0)
        |=> r_s1_valid && r_s1.underrun && !r_s1.code_valid)
        else $error("tick on empty ring did not flag underrun");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_count) && $stable(r_rd_pos) && $stable(r_wr_pos))
        else $error("ring state moved without a word");

endmodule

// ----- tb/dac_sample_playout_fifo_tb.sv -----
module dac_sample_playout_fifo_tb import dspf_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 512;
    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RESET_CYCLES   = 12;

    typedef struct {
        logic                kind;
        logic [SAMPLE_W-1:0] sample_word;
    } t_sample_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dspf_in_if  in_if ();
    dspf_out_if out_if ();

    dac_sample_playout_fifo #(
        .DEPTH (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_sample_item words_to_send[$];
    t_result      codes_due[$];
    int           errors;
    int           cycle_count;
    int           idle_cycles;
    logic         quiet;

    // Playback ring as the block should hold it.
    logic [CODE_W-1:0] ring [DEPTH];
    int unsigned       oldest;
    int unsigned       held;

    // Both sides run without gaps for a while in the middle of the run.
    assign quiet = (cycle_count >= 200) && (cycle_count < 450);

    // Adding half scale to the top twelve bits only flips their sign bit.
    function automatic logic [CODE_W-1:0] word_to_code(input logic [SAMPLE_W-1:0] w);
        logic [SAMPLE_W-1:0] sample;
        sample = {w[7:0], w[15:8]};
        return {~sample[15], sample[14:4]};
    endfunction

    function void step_playout(input logic kind, input logic [SAMPLE_W-1:0] w,
                               output t_result r);
        r = '0;
        if (kind == KIND_PUSH) begin
            if (held < DEPTH) begin
                ring[(oldest + held) % DEPTH] = word_to_code(w);
                held++;
                r.status.accepted = 1'b1;
            end
        end else if (held > 0) begin
            r.dac_code = ring[oldest];
            r.status.code_valid = 1'b1;
            oldest = (oldest + 1) % DEPTH;
            held--;
        end else begin
            r.status.underrun = 1'b1;
        end
        r.status.fill_level = FILL_W'(held);
    endfunction

    task automatic queue_word(input logic kind, input logic [SAMPLE_W-1:0] w);
        t_sample_item item;
        item.kind = kind;
        item.sample_word = w;
        words_to_send.push_back(item);
    endtask

    task automatic check_field(input string name, input int unsigned due, input int unsigned got);
        if (due != got) begin
            $error("%s: expected %0d, got %0d", name, due, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
        end
    end

    // Driver: predicts each accepted word, then offers the next one.
    always @(posedge i_clk) begin
        t_sample_item next_word;
        t_result      due;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                step_playout(in_if.kind, in_if.sample_word, due);
                codes_due.push_back(due);
            end
            if (!in_if.valid || in_if.ready) begin
                if (words_to_send.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
                    next_word = words_to_send.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.kind        <= next_word.kind;
                    in_if.sample_word <= next_word.sample_word;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (codes_due.size() == 0) begin
                    $error("result word with no prediction waiting");
                    errors++;
                end else begin
                    due = codes_due.pop_front();
                    check_field("accepted", due.status.accepted, out_if.accepted);
                    check_field("code_valid", due.status.code_valid, out_if.code_valid);
                    check_field("dac_code", due.dac_code, out_if.dac_code);
                    check_field("underrun", due.status.underrun, out_if.underrun);
                    check_field("fill_level", due.status.fill_level, out_if.fill_level);
                end
            end
            out_if.ready <= quiet || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.kind        = KIND_PUSH;
        in_if.sample_word = '0;
        out_if.ready      = 1'b0;
        errors            = 0;
        oldest            = 0;
        held              = 0;

        // Tick on an empty ring, then the extremes of the sample range.
        queue_word(KIND_TICK, 16'h1234);
        queue_word(KIND_PUSH, 16'h0000);
        queue_word(KIND_PUSH, 16'hFFFF);
        queue_word(KIND_PUSH, 16'h0080);
        queue_word(KIND_PUSH, 16'hFF7F);
        queue_word(KIND_PUSH, 16'h00FF);
        queue_word(KIND_PUSH, 16'h0F00);
        queue_word(KIND_PUSH, 16'hF0FF);
        queue_word(KIND_PUSH, 16'h5AA5);
        queue_word(KIND_PUSH, 16'hA55A);
        repeat (9) queue_word(KIND_TICK, 16'hFFFF);
        queue_word(KIND_TICK, 16'h0000);
        // A tick right behind a push into an empty ring.
        queue_word(KIND_PUSH, 16'h3C7E);
        queue_word(KIND_TICK, 16'h0000);
        queue_word(KIND_TICK, 16'h0000);

        // Fill past full so that the last pushes are refused.
        repeat (DEPTH + 4) queue_word(KIND_PUSH, 16'($urandom));
        // Mostly ticks near full, so pops and pushes alternate around the top.
        repeat (30) begin
            queue_word(($urandom_range(99) < 70) ? KIND_TICK : KIND_PUSH, 16'($urandom));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || in_if.valid || codes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 6) @(posedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
